@@ rtl/core/utt_pkg.sv @@
`default_nettype none

package utt_pkg;

	// Surrogate ranges and UTF-8 code points
	localparam logic [15:0] HighFirst = 16'hD800;
	localparam logic [15:0] LowFirst  = 16'hDC00;
	localparam logic [15:0] LowEnd    = 16'hE000;
	localparam logic [20:0] PlaneOne  = 21'h10000;
	localparam logic [7:0]  Backslash = 8'h5C;
	localparam logic [7:0]  Slash     = 8'h2F;

	// Most bytes one transfer can give: a flushed surrogate plus a 3-byte unit
	localparam int unsigned MaxBytes = 6;

	// One encoded code point: up to four bytes, count 1..4
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} enc_t;

	// One result group: all bytes caused by one input transfer
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0]               last;
		logic                     fin;
		logic                     empty;
	} grp_t;

	// Replace a backslash by a forward slash
	function automatic logic [7:0] fix_slash(input logic [7:0] b);
		fix_slash = (b == Backslash) ? Slash : b;
	endfunction

	// Encode a code point below 0x110000 as UTF-8, replacing a backslash by a forward slash
	function automatic enc_t encode(input logic [20:0] c);
		enc_t e;
		e.bytes = '0;
		if (c < 21'h80) begin
			e.bytes[0] = fix_slash(c[7:0]);
			e.count    = 3'd1;
		end else if (c < 21'h800) begin
			e.bytes[0] = {3'b110, c[10:6]};
			e.bytes[1] = {2'b10, c[5:0]};
			e.count    = 3'd2;
		end else if (c < PlaneOne) begin
			e.bytes[0] = {4'b1110, c[15:12]};
			e.bytes[1] = {2'b10, c[11:6]};
			e.bytes[2] = {2'b10, c[5:0]};
			e.count    = 3'd3;
		end else begin
			e.bytes[0] = {5'b11110, c[20:18]};
			e.bytes[1] = {2'b10, c[17:12]};
			e.bytes[2] = {2'b10, c[11:6]};
			e.bytes[3] = {2'b10, c[5:0]};
			e.count    = 3'd4;
		end
		encode = e;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/utt_group_enc.sv @@
`default_nettype none

module utt_group_enc (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [15:0]   code_unit,
	input  wire logic          final_unit,
	output utt_pkg::grp_t      grp,
	output logic               grp_load
);
	import utt_pkg::*;

	logic       held_valid_q;
	logic [9:0] held_bits_q;
	logic       terminated_q;

	logic       is_high;
	logic       is_low;
	logic       pair;
	logic       en_a;
	logic       en_b;
	logic [20:0] a_code;
	enc_t       enc_a;
	enc_t       enc_b;
	logic [2:0] na;
	logic [2:0] nb;
	logic [2:0] n;
	logic [7:0][7:0] a8;
	logic [7:0][7:0] b8;
	logic [2:0] j;

	// Classify the unit against the surrogate ranges
	assign is_high = (code_unit >= HighFirst) && (code_unit < LowFirst);
	assign is_low  = (code_unit >= LowFirst) && (code_unit < LowEnd);
	assign pair    = held_valid_q && is_low;

	// First part: surrogate pair or flushed lone high surrogate
	assign en_a   = !terminated_q && held_valid_q;
	assign a_code = pair ? (PlaneOne + 21'({held_bits_q, code_unit[9:0]}))
	                     : 21'({6'b110110, held_bits_q});
	assign enc_a  = encode(a_code);

	// Second part: the unit itself unless it is held, is or follows a zero unit, or was paired
	assign en_b  = !terminated_q && !pair && (code_unit != 16'h0)
	               && !(is_high && !final_unit);
	assign enc_b = encode(21'(code_unit));

	assign na = en_a ? enc_a.count : 3'd0;
	assign nb = en_b ? enc_b.count : 3'd0;
	assign n  = na + nb;
	assign a8 = {32'h0, enc_a.bytes};
	// Zero the second part when it gives nothing, so an empty result carries byte 0
	assign b8 = {32'h0, (en_b ? enc_b.bytes : 32'h0)};

	// Pack both parts into one group
	always_comb begin
		grp.bytes = '0;
		j         = '0;
		for (int i = 0; i < MaxBytes; i++) begin
			j = 3'(i) - na;
			grp.bytes[i] = (3'(i) < na) ? a8[i] : b8[j];
		end
		grp.empty = (n == 3'd0);
		grp.last  = grp.empty ? 3'd0 : (n - 3'd1);
		grp.fin   = final_unit;
		grp_load  = !grp.empty || final_unit;
	end

	// Advance the surrogate and terminator state on each accepted unit until a zero unit; the final unit clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
			terminated_q <= 1'b0;
		end else if (accept) begin
			if (final_unit) begin
				held_valid_q <= 1'b0;
				held_bits_q  <= '0;
				terminated_q <= 1'b0;
			end else if (!terminated_q) begin
				held_valid_q <= is_high;
				if (is_high) begin
					held_bits_q <= code_unit[9:0];
				end
				if (code_unit == 16'h0) begin
					terminated_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/utf16_to_utf8_transcoder_unit.sv @@
`default_nettype none

// UTF-16 to UTF-8 name transcoder. Each input transfer carries one UTF-16 code
// unit; each output transfer carries one UTF-8 byte. A unit is encoded in the
// cycle it is taken and its bytes (up to six when a held high surrogate is
// flushed) go to a two-deep group queue, from whose second stage they are sent.
// The output port sends one byte per cycle while dst_stall is low, and that
// port sets the rate: a unit's bytes leave one after another, so ASCII text
// flows at one unit per cycle; units with more bytes hold later units back.
// A high surrogate that is not final waits for the next unit and gives nothing
// at once. On the unit marked final, a name that would give no byte ends with
// one result whose byte_valid is low.
module utf16_to_utf8_transcoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [15:0] code_unit,
	input  wire logic        final_unit,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             run_end,
	output logic             name_end
);
	import utt_pkg::*;

	logic       accept;
	grp_t       grp;
	logic       grp_load;
	grp_t       grp_s1;
	logic       valid_s1;
	grp_t       grp_s2;
	logic       valid_s2;
	logic [2:0] idx_q;
	logic       xfer;
	logic       s2_done;
	logic       s1_move;

	assign accept = src_valid && !src_stall;

	utt_group_enc u_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.grp        (grp),
		.grp_load   (grp_load)
	);

	// Handshake between the two group stages
	assign xfer      = dst_valid && !dst_stall;
	assign s2_done   = xfer && (idx_q == grp_s2.last);
	assign s1_move   = valid_s1 && (!valid_s2 || s2_done);
	assign src_stall = valid_s1 && !s1_move;

	// Hold the freshly encoded group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && grp_load) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && grp_load) begin
			grp_s1 <= grp;
		end
	end

	// Serialize the group one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (xfer) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			grp_s2 <= grp_s1;
		end
	end

	assign dst_valid  = valid_s2;
	assign out_byte   = grp_s2.bytes[idx_q];
	assign byte_valid = !grp_s2.empty;
	assign run_end    = (idx_q == grp_s2.last);
	assign name_end   = grp_s2.fin && (idx_q == grp_s2.last);

`ifndef ASSERT_OFF
	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (idx_q <= grp_s2.last))
		else $error("byte index past end of group");

	a_stall_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && valid_s2))
		else $error("input stalled with a free group stage");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !run_end) |=> dst_valid)
		else $error("group dropped before its last byte");

	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && !byte_valid) |-> (run_end && name_end))
		else $error("empty result that does not close the name");
`endif

endmodule

`default_nettype wire
